>>> rtl/ssm_pkg.sv
// Package: shared types and constants of the spring strain monitor.
`timescale 1ns / 1ps
package ssm_pkg;

   localparam logic [15:0] ADJUST_RESET = 16'd4096;
   localparam int          INDEX_W      = 10;
   localparam int          MAX_DEPTH    = 1024;

   localparam logic [1:0] EVT_NONE     = 2'd0;
   localparam logic [1:0] EVT_STRESSED = 2'd1;
   localparam logic [1:0] EVT_BROKEN   = 2'd2;
   localparam logic [1:0] EVT_IGNORED  = 2'd3;

   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_CHECK = 1'b1;

   localparam logic [5:0] ROOT_STEPS_M1 = 6'd32;
   localparam logic [5:0] DIV_STEPS_M1  = 6'd15;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_ROOT, ST_EFF, ST_PROD, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_DX, MUL_DY, MUL_REST
   } mul_sel_type;

   typedef enum logic [2:0] {
      FIN_NONE, FIN_ZERO, FIN_ADD, FIN_IGNORED, FIN_CHECK
   } fin_kind_type;

   typedef struct packed {
      logic         clr_step;
      logic         load;
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         acc_load;
      logic         acc_add;
      logic         root_step;
      logic         mem_read;
      logic         eff_step;
      logic         div_init;
      logic         div_step;
      fin_kind_type fin;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic idx_ok;
      logic is_check;
      logic broken;
      logic out_free;
   } status_type;

endpackage

>>> rtl/ssm_req_if.sv
// Interface: input transaction channel of the spring strain monitor.
`timescale 1ns / 1ps
interface ssm_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [9:0]  spring_index;
   logic signed [31:0] end_a_x;
   logic signed [31:0] end_a_y;
   logic signed [31:0] end_b_x;
   logic signed [31:0] end_b_y;
   logic [15:0] material_strength;

   modport source (output valid, action, spring_index, end_a_x, end_a_y, end_b_x, end_b_y,
                   material_strength, input ready);
   modport sink (input valid, action, spring_index, end_a_x, end_a_y, end_b_x, end_b_y,
                 material_strength, output ready);
endinterface

>>> rtl/ssm_rsp_if.sv
// Interface: result transaction channel of the spring strain monitor.
`timescale 1ns / 1ps
interface ssm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_code;
   logic [15:0] strain_value;

   modport source (output valid, event_code, strain_value, input ready);
   modport sink (input valid, event_code, strain_value, output ready);
endinterface

>>> rtl/ssm_ctrl.sv
// Controller state machine sequencing the spring strain datapath.
`timescale 1ns / 1ps
module ssm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssm_pkg::status_type status,
   output ssm_pkg::cmd_type    cmd
);

   ssm_pkg::state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic go_check;

   assign go_check = status.idx_ok && status.is_check && !status.broken;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssm_pkg::ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ssm_pkg::ST_CLEAR: if (status.clr_last) state_in = ssm_pkg::ST_IDLE;
         ssm_pkg::ST_IDLE:  if (req_valid) state_in = ssm_pkg::ST_SQX;
         ssm_pkg::ST_SQX:   state_in = ssm_pkg::ST_SQY;
         ssm_pkg::ST_SQY:   state_in = ssm_pkg::ST_SUM;
         ssm_pkg::ST_SUM: begin
            state_in = ssm_pkg::ST_ROOT;
            cnt_in   = ssm_pkg::ROOT_STEPS_M1;
         end
         ssm_pkg::ST_ROOT: begin
            if (cnt_ff == '0) state_in = go_check ? ssm_pkg::ST_EFF : ssm_pkg::ST_DONE;
            else cnt_in = cnt_ff - 6'd1;
         end
         ssm_pkg::ST_EFF:   state_in = ssm_pkg::ST_PROD;
         ssm_pkg::ST_PROD: begin
            state_in = ssm_pkg::ST_DIV;
            cnt_in   = ssm_pkg::DIV_STEPS_M1;
         end
         ssm_pkg::ST_DIV: begin
            if (cnt_ff == '0) state_in = ssm_pkg::ST_DONE;
            else cnt_in = cnt_ff - 6'd1;
         end
         ssm_pkg::ST_DONE:  if (status.out_free) state_in = ssm_pkg::ST_IDLE;
         default:           state_in = ssm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.fin   = ssm_pkg::FIN_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ssm_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         ssm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ssm_pkg::ST_SQX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ssm_pkg::MUL_DX;
         end
         ssm_pkg::ST_SQY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = ssm_pkg::MUL_DY;
            cmd.acc_load = 1'b1;
         end
         ssm_pkg::ST_SUM: begin
            cmd.acc_add  = 1'b1;
            cmd.mem_read = 1'b1;
         end
         ssm_pkg::ST_ROOT: cmd.root_step = 1'b1;
         ssm_pkg::ST_EFF:  cmd.eff_step = 1'b1;
         ssm_pkg::ST_PROD: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = ssm_pkg::MUL_REST;
            cmd.div_init = 1'b1;
         end
         ssm_pkg::ST_DIV:  cmd.div_step = 1'b1;
         ssm_pkg::ST_DONE: begin
            if (status.out_free) begin
               if (!status.idx_ok)        cmd.fin = ssm_pkg::FIN_ZERO;
               else if (!status.is_check) cmd.fin = ssm_pkg::FIN_ADD;
               else if (status.broken)    cmd.fin = ssm_pkg::FIN_IGNORED;
               else                       cmd.fin = ssm_pkg::FIN_CHECK;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

>>> rtl/ssm_datapath.sv
// Datapath: spring tables, shared multiplier, square root and strain divider.
`timescale 1ns / 1ps
module ssm_datapath #(
   parameter int SPRING_COUNT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data,
   input  logic                req_action,
   input  logic [9:0]          req_spring_index,
   input  logic signed [31:0]  req_end_a_x,
   input  logic signed [31:0]  req_end_a_y,
   input  logic signed [31:0]  req_end_b_x,
   input  logic signed [31:0]  req_end_b_y,
   input  logic [15:0]         req_material_strength,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [1:0]          rsp_event_code,
   output logic [15:0]         rsp_strain_value,
   input  ssm_pkg::cmd_type    cmd,
   output ssm_pkg::status_type status
);

   localparam int DEPTH = (SPRING_COUNT > ssm_pkg::MAX_DEPTH) ? ssm_pkg::MAX_DEPTH
                                                             : SPRING_COUNT;
   localparam int AW = $clog2(DEPTH);

   logic [48:0] spring_mem [DEPTH];
   logic [1:0]  flag_mem [DEPTH];

   logic [15:0] adjust_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic        action_ff, idx_ok_ff;
   logic [AW-1:0] addr_ff;
   logic [15:0] strength_ff;
   logic [32:0] dx_ff, dy_ff;
   logic [65:0] prod_ff, acc_ff;
   logic [35:0] rem_ff;
   logic [32:0] root_ff;
   logic [48:0] spring_rd_ff;
   logic [1:0]  flag_rd_ff;
   logic [31:0] eff_ff;
   logic [32:0] dev_ff;
   logic [40:0] drem_ff;
   logic [47:0] ddiv_ff;
   logic [15:0] quo_ff;
   logic        rsp_valid_ff;
   logic [1:0]  code_ff;
   logic [15:0] strain_ff;

   logic signed [32:0] diff_x, diff_y;
   logic [32:0] rest_rd;
   logic [32:0] mul_a, mul_b;
   logic [37:0] root_rs, root_trial;
   logic        root_ge;
   logic        div_ge;
   logic        sat, brk, strs;
   logic [15:0] strain_calc;
   logic        flag_we;
   logic [AW-1:0] flag_waddr;
   logic [1:0]  flag_wdata;
   logic [1:0]  code_calc;

   assign diff_x  = 33'(req_end_b_x) - 33'(req_end_a_x);
   assign diff_y  = 33'(req_end_b_y) - 33'(req_end_a_y);
   assign rest_rd = spring_rd_ff[48:16];

   // item capture and configuration
   always_ff @(posedge clock) begin
      if (reset) adjust_ff <= ssm_pkg::ADJUST_RESET;
      else if (csr_wr_en) adjust_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_cnt_ff <= '0;
      else if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_action;
         idx_ok_ff   <= (17'(req_spring_index) < 17'(SPRING_COUNT));
         addr_ff     <= req_spring_index[AW-1:0];
         strength_ff <= req_material_strength;
         dx_ff       <= diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
         dy_ff       <= diff_y[32] ? 33'(-diff_y) : 33'(diff_y);
      end
   end

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         ssm_pkg::MUL_DX: begin mul_a = dx_ff; mul_b = dx_ff; end
         ssm_pkg::MUL_DY: begin mul_a = dy_ff; mul_b = dy_ff; end
         ssm_pkg::MUL_REST: begin mul_a = {1'b0, eff_ff}; mul_b = rest_rd; end
         default: begin mul_a = dx_ff; mul_b = dx_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) prod_ff <= 66'(mul_a) * 66'(mul_b);
   end

   // radicand accumulation and one root bit per cycle
   assign root_rs    = {rem_ff, acc_ff[65:64]};
   assign root_trial = {3'b0, root_ff, 2'b01};
   assign root_ge    = root_rs >= root_trial;

   always_ff @(posedge clock) begin
      if (cmd.acc_load) acc_ff <= prod_ff;
      else if (cmd.acc_add) acc_ff <= acc_ff + prod_ff;
      else if (cmd.root_step) acc_ff <= {acc_ff[63:0], 2'b00};
      if (cmd.acc_add) begin
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rem_ff  <= root_ge ? 36'(root_rs - root_trial) : 36'(root_rs);
         root_ff <= {root_ff[31:0], root_ge};
      end
   end

   // spring tables
   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         spring_rd_ff <= spring_mem[addr_ff];
         flag_rd_ff   <= flag_mem[addr_ff];
      end
      if (cmd.fin == ssm_pkg::FIN_ADD) spring_mem[addr_ff] <= {root_ff, strength_ff};
   end

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
   end

   // strain ratio, one quotient bit per cycle
   assign div_ge = {7'b0, drem_ff} >= ddiv_ff;

   always_ff @(posedge clock) begin
      if (cmd.eff_step) begin
         eff_ff <= 32'(adjust_ff) * 32'(spring_rd_ff[15:0]);
         dev_ff <= (rest_rd > root_ff) ? rest_rd - root_ff : root_ff - rest_rd;
      end
      if (cmd.div_init) begin
         drem_ff <= {dev_ff, 8'b0};
         ddiv_ff <= {rest_rd, 15'b0};
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         drem_ff <= div_ge ? drem_ff - ddiv_ff[40:0] : drem_ff;
         ddiv_ff <= {1'b0, ddiv_ff[47:1]};
         quo_ff  <= {quo_ff[14:0], div_ge};
      end
   end

   assign sat  = {8'b0, dev_ff} >= {rest_rd, 8'b0};
   assign strain_calc = sat ? ((dev_ff == '0) ? 16'd0 : 16'hFFFF) : quo_ff;
   assign brk  = {13'b0, dev_ff, 20'b0} > prod_ff;
   assign strs = {11'b0, dev_ff, 22'b0} > prod_ff;

   always_comb begin
      flag_we    = 1'b0;
      flag_waddr = addr_ff;
      flag_wdata = flag_rd_ff;
      code_calc  = ssm_pkg::EVT_NONE;
      if (cmd.clr_step) begin
         flag_we    = 1'b1;
         flag_waddr = clr_cnt_ff;
         flag_wdata = 2'b00;
      end else begin
         case (cmd.fin)
            ssm_pkg::FIN_ADD: begin
               flag_we    = 1'b1;
               flag_wdata = 2'b00;
            end
            ssm_pkg::FIN_CHECK: begin
               flag_we = 1'b1;
               if (brk) begin
                  flag_wdata = {1'b1, flag_rd_ff[0]};
                  code_calc  = ssm_pkg::EVT_BROKEN;
               end else if (strs) begin
                  flag_wdata = 2'b01;
                  if (!flag_rd_ff[0]) code_calc = ssm_pkg::EVT_STRESSED;
               end else begin
                  flag_wdata = 2'b00;
               end
            end
            ssm_pkg::FIN_IGNORED: code_calc = ssm_pkg::EVT_IGNORED;
            default: flag_we = 1'b0;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.fin != ssm_pkg::FIN_NONE) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.fin != ssm_pkg::FIN_NONE) begin
         code_ff   <= code_calc;
         strain_ff <= (cmd.fin == ssm_pkg::FIN_CHECK) ? strain_calc : 16'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_code   = code_ff;
   assign rsp_strain_value = strain_ff;

   assign status.clr_last = clr_cnt_ff == AW'(DEPTH - 1);
   assign status.idx_ok   = idx_ok_ff;
   assign status.is_check = action_ff == ssm_pkg::ACT_CHECK;
   assign status.broken   = flag_rd_ff[1];
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

>>> rtl/spring_strain_monitor_core.sv
// Top level of the spring strain monitor.
`timescale 1ns / 1ps
// Spring strain monitor: holds a table of springs and answers each add or check
// transaction with exactly one result (event code and Q8.8 strain). One
// transaction is handled at a time. A check forms its result from two squares
// on a shared 33x33 multiplier, their sum, a bit-serial square root, the
// strength and limit products and a restoring divider, then posts the result.
// An add, an out-of-range index or a check on a broken spring posts its result
// after the root, which is still formed, without the products and the divider.
// The controller then returns to idle before it accepts the next transaction.
// A new transaction is accepted while the previous result waits in the output
// register; a result that is still waiting when the next one is ready holds
// the controller. After reset the flag table is cleared one entry per cycle,
// all min(SPRING_COUNT, 1024) entries, before the first transaction is accepted.
module spring_strain_monitor_core #(
   parameter int SPRING_COUNT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ssm_req_if.sink     req_ch,
   ssm_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   ssm_pkg::cmd_type    cmd;
   ssm_pkg::status_type status;

   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssm_datapath #(
      .SPRING_COUNT (SPRING_COUNT)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_action            (req_ch.action),
      .req_spring_index      (req_ch.spring_index),
      .req_end_a_x           (req_ch.end_a_x),
      .req_end_a_y           (req_ch.end_a_y),
      .req_end_b_x           (req_ch.end_b_x),
      .req_end_b_y           (req_ch.end_b_y),
      .req_material_strength (req_ch.material_strength),
      .rsp_ready             (rsp_ch.ready),
      .rsp_valid             (rsp_ch.valid),
      .rsp_event_code        (rsp_ch.event_code),
      .rsp_strain_value      (rsp_ch.strain_value),
      .cmd                   (cmd),
      .status                (status)
   );

endmodule
